### sv/dfe_pkg.sv
`default_nettype none

package dfe_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER = 2'd0,
        REG_FOOTER = 2'd1
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic in_take;   // accept the presented rx byte
        logic rd_start;  // read entry 0, reset read pointer
        logic rd_next;   // advance read pointer and read
    } dfe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_header;
        logic is_footer;
        logic frame_open;
        logic fill_nonzero;
        logic rd_last;
    } dfe_status_t;

endpackage

`default_nettype wire

### sv/dfe_datapath.sv
`default_nettype none

module dfe_datapath #(
    parameter int BUF_SIZE = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                 cfg_wdata,
    input  wire logic [7:0]                 rx_byte,
    input  wire dfe_pkg::dfe_cmd_t          cmd,
    output dfe_pkg::dfe_status_t            status,
    output logic [7:0]                      payload_byte,
    output logic [5:0]                      frame_length,
    output logic                            is_last
);
    import dfe_pkg::*;

    localparam int AW = $clog2(BUF_SIZE);
    localparam logic [AW-1:0] FILL_LIMIT = AW'(BUF_SIZE - 1);

    logic [7:0]    header_reg;
    logic [7:0]    footer_reg;
    logic          open_reg;
    logic          open_next;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] fill_next;
    logic [AW-1:0] fill_inc;
    logic [AW-1:0] len_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data_reg;
    logic          hdr_hit;
    logic          ftr_hit;
    logic          do_store;

    logic [7:0]    mem [BUF_SIZE];

    assign hdr_hit  = (rx_byte == header_reg);
    assign ftr_hit  = (rx_byte == footer_reg);
    assign do_store = cmd.in_take && !hdr_hit && !ftr_hit && open_reg;
    assign fill_inc = AW'(fill_reg + 1'b1);

    always_comb begin
        open_next = open_reg;
        fill_next = fill_reg;
        if (cmd.in_take) begin
            if (hdr_hit) begin
                open_next = 1'b1;
                fill_next = '0;
            end else if (ftr_hit) begin
                open_next = 1'b0;
            end else if (open_reg) begin
                fill_next = fill_inc;
                if (fill_inc == FILL_LIMIT) begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= '0;
            footer_reg <= '0;
            open_reg   <= 1'b0;
            fill_reg   <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_HEADER) begin
                header_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == REG_FOOTER) begin
                footer_reg <= cfg_wdata;
            end
            open_reg <= open_next;
            fill_reg <= fill_next;
        end
    end

    assign rd_addr = cmd.rd_start ? '0 : AW'(ptr_reg + 1'b1);

    // capture the frame length when the drain starts
    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            len_reg <= fill_reg;
        end
        if (cmd.rd_start || cmd.rd_next) begin
            ptr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_store) begin
            mem[fill_reg] <= rx_byte;
        end
        if (cmd.rd_start || cmd.rd_next) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.is_header    = hdr_hit;
    assign status.is_footer    = ftr_hit;
    assign status.frame_open   = open_reg;
    assign status.fill_nonzero = (fill_reg != '0);
    assign status.rd_last      = (AW'(ptr_reg + 1'b1) == len_reg);

    assign payload_byte = rd_data_reg;
    assign frame_length = 6'(len_reg);
    assign is_last      = status.rd_last;

endmodule

`default_nettype wire

### sv/dfe_controller.sv
`default_nettype none

module dfe_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire dfe_pkg::dfe_status_t status,
    output dfe_pkg::dfe_cmd_t         cmd
);
    import dfe_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   release_frame;

    assign release_frame = !status.is_header && status.is_footer &&
                           status.frame_open && status.fill_nonzero;

    always_comb begin
        state_next   = state_reg;
        cmd.in_take  = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.rd_next  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.in_take = 1'b1;
                    if (release_frame) begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (m_ready) begin
                    if (status.rd_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_DRAIN);

endmodule

`default_nettype wire

### sv/delimited_frame_extractor_unit.sv
// Header/footer byte framer for one socket stream.
// Input channel (s_valid/s_ready, s_rx_byte): one received byte per beat.
// A byte equal to the header register opens a frame and restarts capture;
// bytes inside an open frame are stored; a byte equal to the footer register
// closes the frame and, if it held at least one byte, releases it.
// Output channel (m_valid/m_ready): one beat per stored byte, in arrival
// order, each with the frame length; m_is_last marks the final byte.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write header (0), footer (1).
// Throughput: one input beat per cycle while no frame drains. A released
// frame shows its first beat in the cycle after the footer beat
// (memory read register), then one beat per cycle while m_ready is high, so
// s_ready stays low for the whole drain; the payload memory's single read
// port sets that drain rate. A stalled receiver holds the current beat and
// the input stays blocked until the last beat is taken.
// Reset clears both registers to 0, closes any frame and zeroes the fill
// count; payload memory contents are not cleared and need no clearing pass.
`default_nettype none

module delimited_frame_extractor_unit #(
    parameter int BUF_SIZE = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_payload_byte,
    output logic [5:0]                         m_frame_length,
    output logic                               m_is_last
);
    import dfe_pkg::*;

    dfe_cmd_t    cmd;
    dfe_status_t status;

    // sequence accept/drain; no datapath logic here
    dfe_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // hold config, fill state and payload memory
    dfe_datapath #(
        .BUF_SIZE (BUF_SIZE)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .rx_byte      (s_rx_byte),
        .cmd          (cmd),
        .status       (status),
        .payload_byte (m_payload_byte),
        .frame_length (m_frame_length),
        .is_last      (m_is_last)
    );

    // never advance the read pointer past the final byte
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_next |-> !status.rd_last)
        else $error("read pointer advanced past frame end");

    // input and output never move a beat in the same cycle
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !m_valid)
        else $error("input accepted during drain");

    // taking the last beat reopens the input
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_last) |=> (s_ready && !m_valid))
        else $error("input not reopened after last beat");

    // a released frame always starts draining on the next cycle
    a_release_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_start |=> (m_valid && m_frame_length != 6'd0 || BUF_SIZE > 64))
        else $error("released frame did not start draining");

endmodule

`default_nettype wire

### tb/dfe_frame_checker.sv
module dfe_frame_checker #(
    parameter int BUF_SIZE = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_payload_byte,
    input  logic [5:0]                    m_frame_length,
    input  logic                          m_is_last,
    output int                            mismatches,
    output int                            pending,
    output int                            frames_released,
    output int                            frames_dropped,
    output int                            beats_compared
);
    import dfe_pkg::*;

    // Watch both channels of the frame extractor, keep a copy of the
    // framing state and compare every released payload beat with the oldest
    // beat still owed.

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] frame_len;
        logic       is_last;
    } payload_beat_t;

    logic [7:0]    header_val;
    logic [7:0]    footer_val;
    logic          in_frame;
    int unsigned   fill;
    logic [7:0]    stash [BUF_SIZE];
    payload_beat_t payload_owed [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Header test wins over footer test, so equal delimiters never release.
    task automatic absorb_rx_byte(input logic [7:0] b);
        int unsigned len;
        if (b == header_val) begin
            fill = 0;
            in_frame = 1'b1;
        end else if (b == footer_val) begin
            if (in_frame && fill != 0) begin
                len = (fill > BUF_SIZE) ? BUF_SIZE : fill;
                for (int unsigned k = 0; k < len; k++) begin
                    payload_owed.push_back('{data: stash[k], frame_len: 6'(len),
                                             is_last: (k == len - 1)});
                end
                frames_released++;
            end
            in_frame = 1'b0;
        end else if (in_frame) begin
            if (fill < BUF_SIZE)
                stash[fill] = b;
            fill++;
            // drop the frame once it holds BUF_SIZE - 1 bytes
            if (fill >= BUF_SIZE - 1) begin
                in_frame = 1'b0;
                frames_dropped++;
            end
        end
    endtask

    always @(posedge aclk) begin
        payload_beat_t got;
        payload_beat_t want;
        if (!aresetn) begin
            header_val = 8'h00;
            footer_val = 8'h00;
            in_frame = 1'b0;
            fill = 0;
            payload_owed.delete();
            mismatches = 0;
            frames_released = 0;
            frames_dropped = 0;
            beats_compared = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HEADER: header_val = cfg_wdata;
                    REG_FOOTER: footer_val = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{data: m_payload_byte, frame_len: m_frame_length, is_last: m_is_last};
                if (payload_owed.size() == 0) begin
                    report_mismatch($sformatf("unexpected payload beat %02h", got.data));
                end else begin
                    want = payload_owed.pop_front();
                    beats_compared++;
                    if (got.data !== want.data)
                        report_mismatch($sformatf("payload_byte got %02h, expected %02h",
                                                  got.data, want.data));
                    if (got.frame_len !== want.frame_len)
                        report_mismatch($sformatf("frame_length got %0d, expected %0d",
                                                  got.frame_len, want.frame_len));
                    if (got.is_last !== want.is_last)
                        report_mismatch($sformatf("is_last got %b, expected %b",
                                                  got.is_last, want.is_last));
                end
            end
            if (s_valid && s_ready)
                absorb_rx_byte(s_rx_byte);
        end
        pending <= payload_owed.size();
    end

endmodule

### tb/delimited_frame_extractor_unit_tb.sv
module delimited_frame_extractor_unit_tb;
    import dfe_pkg::*;

    // Stimulus and verdict for the frame extractor; all prediction and
    // comparison lives in the checker instantiated beside the block.

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_MAX = 17;
    localparam int LONG_HOLD = 300;      // receiver hold-off that backs up the input
    localparam int DRAIN_SLACK = 4;      // cycles for the block to settle after the last beat
    localparam int END_WAIT_LIMIT = 20000;
    localparam int RUN_LIMIT_CYCLES = 300000;
    localparam int OVERFLOW_FRAME = 63;  // first length that drops the frame
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // index beyond the register list

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
    logic [7:0]           cfg_wdata = 8'h00;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_payload_byte;
    logic [5:0]           m_frame_length;
    logic                 m_is_last;

    int mismatches;
    int pending;
    int frames_released;
    int frames_dropped;
    int beats_compared;

    // Pacing knobs: a steady side never idles; the long hold is a one-shot request.
    bit          sender_steady = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned settings_used = 1;  // reset values count as the first setting
    logic [7:0]  cur_header = 8'h00;
    logic [7:0]  cur_footer = 8'h00;

    always #HALF_PERIOD aclk = ~aclk;

    delimited_frame_extractor_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_length (m_frame_length),
        .m_is_last      (m_is_last)
    );

    dfe_frame_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_frame_length  (m_frame_length),
        .m_is_last       (m_is_last),
        .mismatches      (mismatches),
        .pending         (pending),
        .frames_released (frames_released),
        .frames_dropped  (frames_dropped),
        .beats_compared  (beats_compared)
    );

    function automatic int unsigned pick_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Draw a byte that is neither delimiter, so it lands in the payload.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_header || b == cur_footer);
        return b;
    endfunction

    // Offer one beat after a random gap; return at the edge that takes it.
    // With no gap, valid stays high and only the payload advances.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap(sender_steady);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        beats_sent++;
    endtask

    // Drop valid and wait until every owed beat is out and the block has settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // Hold the write for one edge, then drop it before returning so back-to-back
    // writes never lower and raise the enable in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_delimiters(input logic [7:0] h, input logic [7:0] f);
        write_reg(REG_HEADER, h);
        write_reg(REG_FOOTER, f);
        cur_header = h;
        cur_footer = f;
        settings_used++;
    endtask

    // Header, n payload bytes, footer. A noisy frame now and then slips in
    // an unrestricted byte, which may restart or close the frame early.
    task automatic send_frame(input int unsigned n, input bit noisy);
        push_byte(cur_header);
        repeat (n) begin
            if (noisy && $urandom_range(0, 19) == 0)
                push_byte(8'($urandom_range(0, 255)));
            else
                push_byte(plain_byte());
        end
        push_byte(cur_footer);
    endtask

    // Mostly short frames, a few up to twenty bytes.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 6);
        return $urandom_range(7, 20);
    endfunction

    // Well-formed frames with random content, plus broken frames and noise.
    // Run until both the beat goal and the released-frame goal are met.
    task automatic run_random(input int unsigned beat_goal, input int unsigned frame_goal);
        int unsigned beats_at_start;
        int unsigned frames_at_start;
        int unsigned roll;
        beats_at_start = beats_sent;
        frames_at_start = frames_released;
        while (beats_sent - beats_at_start < beat_goal ||
               frames_released - frames_at_start < frame_goal) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                send_frame(pick_len(), 1'b1);
            end else if (roll < 82) begin
                // open a frame and abandon it
                push_byte(cur_header);
                repeat ($urandom_range(1, 5)) push_byte(plain_byte());
            end else if (roll < 90) begin
                push_byte(cur_footer);
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Receiver: draw a stall per beat; honor a long hold-off when requested.
    initial begin : result_sink
        int unsigned hold;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = pick_gap(receiver_steady);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_valid);
        end
    end

    initial begin : stimulus
        logic [7:0] h;
        int unsigned end_wait;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset delimiters are equal: the header test wins, so a zero byte
        // reopens the frame every time and nothing is released.
        push_byte(8'h00);
        push_byte(8'h33);
        push_byte(8'h00);
        wait_idle();

        write_reg(REG_FOOTER, 8'hFF);
        cur_footer = 8'hFF;
        settings_used++;
        push_byte(8'hFF);              // footer on the empty frame left open
        push_byte(8'h00);
        push_byte(8'hFF);              // footer on an empty frame
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h80);
        push_byte(8'hFF);              // two-byte frame
        push_byte(8'h00);
        push_byte(8'h12);
        push_byte(8'h00);              // header inside a frame: restart empty
        push_byte(8'h34);
        push_byte(8'hFF);
        wait_idle();

        // A write beyond the register list must leave both delimiters alone.
        write_reg(REG_SPARE, 8'h34);
        push_byte(8'h00);
        push_byte(8'h34);
        push_byte(8'hFF);
        wait_idle();

        set_delimiters(8'hFF, 8'h00);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'hFE);
        push_byte(8'h00);
        wait_idle();

        // A frame that overflows is dropped; its footer must stay silent.
        set_delimiters(8'hA5, 8'h5A);
        send_frame(OVERFLOW_FRAME, 1'b0);
        wait_idle();

        // Back up the block: stall the receiver while the sender keeps offering.
        set_delimiters(8'h7E, 8'h7D);
        sender_steady = 1'b1;
        long_hold_req = 1'b1;
        send_frame(10, 1'b0);
        send_frame(3, 1'b0);
        sender_steady = 1'b0;
        wait_idle();

        h = 8'($urandom_range(0, 255));
        set_delimiters(h, h ^ 8'($urandom_range(1, 255)));
        run_random(12, 3);

        // Drain what is owed, with a bound, then let the block settle.
        s_valid <= 1'b0;
        @(posedge aclk);
        end_wait = 0;
        while (pending != 0 && end_wait < END_WAIT_LIMIT) begin
            @(posedge aclk);
            end_wait++;
        end
        repeat (DRAIN_SLACK) @(posedge aclk);

        if (pending != 0)
            $display("%0d expected payload beats never arrived", pending);
        $display("Covered %0d input beats over %0d delimiter settings", beats_sent,
                 settings_used);
        $display("%0d frames released, %0d dropped on overflow, %0d payload beats compared",
                 frames_released, frames_dropped, beats_compared);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Run limit reached with %0d payload beats outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
